### rtl/core/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  // width of the window size register
  localparam int unsigned CFG_W = 7;

  // per-cycle control broadcast from the top level to every cell
  typedef struct packed {
    logic step;   // a sample request is taken this cycle
    logic shift;  // every cell takes its contents from the next cell
    logic clear;  // start of a new stream: stored candidates are void
  } swm_ctrl_t;

endpackage

### rtl/core/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned AGE_W        = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::swm_ctrl_t             ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  // keep flag of the cell in front
  input  logic                           keep_prev_i,
  // contents of the cell behind
  input  logic                           nb_valid_i,
  input  logic                           nb_keep_i,
  input  logic                           nb_slot_i,
  input  logic signed [SAMPLE_WIDTH-1:0] nb_value_i,
  input  logic [AGE_W-1:0]               nb_age_i,
  // own contents and flags
  output logic                           valid_o,
  output logic                           keep_o,
  output logic                           slot_o,
  output logic signed [SAMPLE_WIDTH-1:0] value_o,
  output logic [AGE_W-1:0]               age_o,
  output logic signed [SAMPLE_WIDTH-1:0] value_nxt_o
);

  logic                           valid_r, valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] value_r, value_nxt;
  logic [AGE_W-1:0]               age_r, age_nxt;

  logic                           src_valid, src_keep, src_slot;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic [AGE_W-1:0]               src_age;

  // survives the back eviction: strictly smaller candidates go
  assign keep_o  = valid_r & ~ctrl_i.clear & ~(sample_i > value_r);
  // first cell past the survivors takes the new sample
  assign slot_o  = keep_prev_i & ~keep_o;
  assign valid_o = valid_r;
  assign value_o = value_r;
  assign age_o   = age_r;

  always_comb begin
    if (ctrl_i.shift) begin
      src_valid = nb_valid_i;
      src_keep  = nb_keep_i;
      src_slot  = nb_slot_i;
      src_value = nb_value_i;
      src_age   = nb_age_i;
    end else begin
      src_valid = valid_r;
      src_keep  = keep_o;
      src_slot  = slot_o;
      src_value = value_r;
      src_age   = age_r;
    end

    valid_nxt = valid_r;
    value_nxt = value_r;
    age_nxt   = age_r;
    if (ctrl_i.step) begin
      if (src_keep) begin
        valid_nxt = 1'b1;
        value_nxt = src_value;
        age_nxt   = src_age + AGE_W'(1);
      end else if (src_slot) begin
        valid_nxt = 1'b1;
        value_nxt = sample_i;
        age_nxt   = '0;
      end else begin
        valid_nxt = 1'b0;
      end
    end else if (ctrl_i.shift) begin
      // purge move: plain copy, no aging
      valid_nxt = src_valid;
      value_nxt = src_value;
      age_nxt   = src_age;
    end
  end

  assign value_nxt_o = value_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

endmodule

### rtl/core/sliding_window_maximum_core.sv
`timescale 1ns / 1ps

// Running maximum of the last window_size signed samples (dilation). The
// candidates of a monotonic deque live in a row of WINDOW_MAX cells, front
// in cell 0; each sample compares against every cell at once, ages the
// survivors, drops an expired front entry by shifting the row one place and
// writes the sample into the first free cell, all in the same cycle. One
// sample request is taken per clock unless results back up or the row is
// shedding; the result goes to the output register once window_size
// samples have been seen since reset or since a request flagged
// first_of_stream. The output register lets a new request in while a
// result is being taken. After window_size is lowered, the row first sheds
// the candidates now too old, one per cycle, with in_tready low meanwhile.
// window_size 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX.
module sliding_window_maximum_core #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // sample
  input  logic [0:0]                          in_tuser,   // first_of_stream
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,  // window_max
  // window size register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int unsigned N      = WINDOW_MAX;
  localparam int unsigned DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned CW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned WW     = (CW > swm_pkg::CFG_W) ? CW : swm_pkg::CFG_W;

  // ---- configuration ----
  logic [swm_pkg::CFG_W-1:0] window_size_r;
  logic                      cfg_fire;
  logic [WW-1:0]             w_wide;
  logic [CW-1:0]             w_eff;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swm_pkg::CFG_W'(1);
    end else if (cfg_fire) begin
      window_size_r <= cfg_data;
    end
  end

  // clamp to 1..WINDOW_MAX
  always_comb begin
    w_wide = WW'(window_size_r);
    if (w_wide == '0) begin
      w_wide = WW'(1);
    end else if (w_wide > WW'(WINDOW_MAX)) begin
      w_wide = WW'(WINDOW_MAX);
    end
    w_eff = w_wide[CW-1:0];
  end

  // ---- cell row ----
  // index N is the empty slot behind the last cell
  logic                           valid_a [N+1];
  logic                           keep_a  [N+1];
  logic                           slot_a  [N+1];
  logic signed [SAMPLE_WIDTH-1:0] value_a [N+1];
  logic [CW-1:0]                  age_a   [N+1];
  logic                           keep_prev [N+1];
  logic signed [SAMPLE_WIDTH-1:0] front_nxt;
  logic [N-1:0]                   valid_vec;

  logic                           step, clear, drop, purge;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  swm_pkg::swm_ctrl_t             ctrl;

  assign sample = $signed(in_tdata[SAMPLE_WIDTH-1:0]);
  assign clear  = in_tuser[0];

  assign valid_a[N] = 1'b0;
  assign keep_a[N]  = 1'b0;
  // full row with an expiring front: the sample enters from behind the last cell
  assign slot_a[N]  = keep_prev[N];
  assign value_a[N] = '0;
  assign age_a[N]   = '0;

  // front entry leaves the window when this sample ages it
  assign drop  = step & ~clear & valid_a[0] &
                 ((({1'b0, age_a[0]}) + (CW+1)'(1)) >= {1'b0, w_eff});
  // more than the front entry expired: only after the window shrank
  assign purge = valid_a[1] &
                 ((({1'b0, age_a[1]}) + (CW+1)'(1)) >= {1'b0, w_eff});

  always_comb begin
    ctrl.step  = step;
    ctrl.shift = drop | (purge & ~step);
    ctrl.clear = clear;
  end

  // dropped front still counts as occupied so the sample lands behind it
  always_comb begin
    for (int i = 0; i < N + 1; i++) begin
      if (i == 0) begin
        keep_prev[i] = 1'b1;
      end else if (i == 1) begin
        keep_prev[i] = keep_a[0] | drop;
      end else begin
        keep_prev[i] = keep_a[i-1];
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] value_nxt;

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (CW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl_i      (ctrl),
      .sample_i    (sample),
      .keep_prev_i (keep_prev[g]),
      .nb_valid_i  (valid_a[g+1]),
      .nb_keep_i   (keep_a[g+1]),
      .nb_slot_i   (slot_a[g+1]),
      .nb_value_i  (value_a[g+1]),
      .nb_age_i    (age_a[g+1]),
      .valid_o     (valid_a[g]),
      .keep_o      (keep_a[g]),
      .slot_o      (slot_a[g]),
      .value_o     (value_a[g]),
      .age_o       (age_a[g]),
      .value_nxt_o (value_nxt)
    );

    assign valid_vec[g] = valid_a[g];
    if (g == 0) begin : g_front
      assign front_nxt = value_nxt;
    end
  end

  // ---- sample count, saturating at the window size ----
  logic [CW-1:0] seen_r, seen_nxt;
  logic          emit;

  always_comb begin
    seen_nxt = clear ? '0 : seen_r;
    if (seen_nxt < w_eff) begin
      seen_nxt = seen_nxt + CW'(1);
    end
    emit = (seen_nxt >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (step) begin
      seen_r <= seen_nxt;
    end
  end

  // ---- handshake and output register ----
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  assign in_tready  = ~purge & (~out_valid_r | out_tready);
  assign step       = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= front_nxt;
    end
  end

  // ---- checks ----
  // a request never leaves more than the front candidate expired
  a_no_purge_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg_fire) |=> !purge)
    else $error("purge needed right after a sample request");

  // occupied cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + N'(1))) == '0)
    else $error("hole in the candidate row");

  // the new sample always leaves at least one candidate
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> valid_vec[0])
    else $error("empty row after a sample request");

  // saturated count with no restart must produce a result
  a_emit_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !clear && seen_r >= w_eff) |=> out_valid_r)
    else $error("result missing with a full window");

endmodule

### dv/swm_window_checker.sv
`timescale 1ns / 1ps

module swm_window_checker #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // sample
  input  logic [0:0]                          in_tuser,   // first_of_stream
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,  // window_max
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]           cfg_data,
  output int                                  mismatch_count,
  output int                                  max_outstanding
);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // candidate row, front at index 0
  sample_t                   cand_val [WINDOW_MAX];
  int unsigned               cand_age [WINDOW_MAX];
  int unsigned               cand_n;
  int unsigned               seen_n;
  logic [swm_pkg::CFG_W-1:0] win_reg;
  sample_t                   max_due [$];
  int                        errs;

  // take one sample; queue the window maximum if the window is full
  function void slide_window(input sample_t s, input logic first);
    int unsigned w;
    int unsigned drop;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    if (first) begin
      cand_n = 0;
      seen_n = 0;
    end
    for (int i = 0; i < cand_n; i++) cand_age[i]++;
    drop = 0;
    while (drop < cand_n && cand_age[drop] >= w) drop++;
    if (drop > 0) begin
      for (int i = 0; i + drop < cand_n; i++) begin
        cand_val[i] = cand_val[i + drop];
        cand_age[i] = cand_age[i + drop];
      end
      cand_n -= drop;
    end
    // equal values stay, only strictly smaller ones go
    while (cand_n > 0 && s > cand_val[cand_n - 1]) cand_n--;
    if (cand_n < WINDOW_MAX) begin
      cand_val[cand_n] = s;
      cand_age[cand_n] = 0;
      cand_n++;
    end
    if (seen_n < w) seen_n++;
    if (seen_n >= w) max_due = {max_due, cand_val[0]};
  endfunction

  always @(posedge clk) begin
    sample_t want;
    sample_t got;
    if (!rst_n) begin
      win_reg = swm_pkg::CFG_W'(1);
      cand_n  = 0;
      seen_n  = 0;
      errs    = 0;
      max_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) win_reg = cfg_data;
      if (in_tvalid && in_tready) slide_window(in_tdata[SAMPLE_WIDTH-1:0], in_tuser[0]);
      if (out_tvalid && out_tready) begin
        got = out_tdata[SAMPLE_WIDTH-1:0];
        if (max_due.size() == 0) begin
          $display("%0t window_max: expected none, got %0d", $time, got);
          errs++;
        end else begin
          want = max_due.pop_front();
          if (got !== want) begin
            $display("%0t window_max: expected %0d, got %0d", $time, want, got);
            errs++;
          end
        end
      end
    end
    mismatch_count  <= errs;
    max_outstanding <= max_due.size();
  end

endmodule

### dv/sliding_window_maximum_core_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sliding window maximum core. Checking lives
// in swm_window_checker, which taps all three channels.
module sliding_window_maximum_core_tb;

  localparam int unsigned WINDOW_MAX     = 64;
  localparam int unsigned SAMPLE_WIDTH   = 16;
  localparam int unsigned DW             = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS   = 1350;
  // worst quiet stretch: the shedding after a shrink plus a long gap on
  // each side; this is many times that
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // sample modes of a random phase
  typedef enum int {
    MODE_NOISE, MODE_NARROW, MODE_FALLING, MODE_RISING, MODE_EXTREME
  } sample_mode_t;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [DW-1:0]             in_tdata   = '0;   // sample
  logic [0:0]                in_tuser   = '0;   // first_of_stream
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [DW-1:0]             out_tdata;         // window_max
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [swm_pkg::CFG_W-1:0] cfg_data   = '0;

  int      mismatches;
  int      pending;
  bit      steady;        // no gaps on either side while set
  int      out_hold;      // remaining result stall cycles
  int      quiet_cycles;  // cycles since the last request on any channel
  int      random_count;
  sample_t ramp;

  sliding_window_maximum_core #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  swm_window_checker #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) window_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatches),
    .max_outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure, independent of what the sample side does
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_hold   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: ends a hung run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // one sample request; valid only drops when a gap follows
  task automatic send_sample(input sample_t s, input bit first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'(s);
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  // window size write, only once the block has drained
  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] w);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a sample with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [swm_pkg::CFG_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return swm_pkg::CFG_W'($urandom_range(1, 8));
    if (r < 75) return swm_pkg::CFG_W'($urandom_range(9, WINDOW_MAX - 1));
    if (r < 85) return swm_pkg::CFG_W'(WINDOW_MAX);
    if (r < 90) return '0;                                 // acts as 1
    // acts as max
    return swm_pkg::CFG_W'($urandom_range(WINDOW_MAX + 1, (1 << swm_pkg::CFG_W) - 1));
  endfunction

  function automatic sample_t next_sample(input sample_mode_t mode);
    int r;
    r = $urandom_range(0, 4);
    // a little noise in every mode
    if ($urandom_range(0, 9) == 0) return sample_t'($urandom_range(0, 65535));
    case (mode)
      MODE_NARROW: begin
        return sample_t'(int'($urandom_range(0, 8)) - 4);
      end
      MODE_FALLING: begin
        // long falling runs fill the candidate row
        ramp = ramp - sample_t'($urandom_range(0, 300));
        return ramp;
      end
      MODE_RISING: begin
        ramp = ramp + sample_t'($urandom_range(0, 300));
        return ramp;
      end
      MODE_EXTREME: begin
        case (r)
          0:       return sample_t'(16'sh7FFF);
          1:       return sample_t'(16'sh8000);
          2:       return sample_t'(0);
          3:       return sample_t'(-1);
          default: return sample_t'(1);
        endcase
      end
      default: begin
        return sample_t'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  initial begin
    logic [swm_pkg::CFG_W-1:0] w;
    int unsigned               w_eff;
    int unsigned               phase_len;
    sample_mode_t              mode;
    bit                        first;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one after reset: every sample comes straight back
    send_sample(sample_t'(16'sh7FFF), 1'b1);
    send_sample(sample_t'(16'sh8000), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(5), 1'b0);

    // window of three: equal samples, the minimum, a restart mid-window
    write_window(3);
    send_sample(sample_t'(7), 1'b1);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(-3), 1'b0);
    send_sample(sample_t'(16'sh8000), 1'b0);
    send_sample(sample_t'(10), 1'b0);
    send_sample(sample_t'(2), 1'b1);
    send_sample(sample_t'(4), 1'b0);

    // falling run keeps eight candidates, then the window shrinks under them
    write_window(8);
    for (int i = 0; i < 8; i++) send_sample(sample_t'(100 - 10 * i), i == 0);
    write_window(2);
    send_sample(sample_t'(20), 1'b0);
    send_sample(sample_t'(10), 1'b0);
    // growth: results pause until five samples are in
    write_window(5);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(2), 1'b0);
    send_sample(sample_t'(3), 1'b0);

    // random phases, each with its own window size and sample shape
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      w     = pick_window();
      w_eff = (w == 0) ? 1 : ((w > WINDOW_MAX) ? WINDOW_MAX : w);
      write_window(w);
      steady    = ($urandom_range(0, 5) == 0);
      mode      = sample_mode_t'($urandom_range(MODE_NOISE, MODE_EXTREME));
      ramp      = $urandom_range(0, 1) ? sample_t'(16'sh7FFF) : sample_t'(16'sh8000);
      phase_len = (w_eff > 8) ? $urandom_range(w_eff + 10, w_eff + 90) : $urandom_range(8, 60);
      // half the phases carry the stream across the size change
      first = ($urandom_range(0, 1) == 1);
      for (int i = 0; i < phase_len; i++) begin
        send_sample(next_sample(mode), first);
        first = ($urandom_range(0, 39) == 0);
        random_count++;
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_maximum_core.sv
dv/swm_window_checker.sv
dv/sliding_window_maximum_core_tb.sv
